// ===== hdl/pfbw_pkg.sv =====
// Shared types and constants of the paged framebuffer bit writer.
`default_nettype none

package pfbw_pkg;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW = $clog2(OPQ_DEPTH);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW = $clog2(RESQ_DEPTH);
  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef struct packed {
    logic [7:0] col;
    logic [3:0] page;
    logic [7:0] val;
    logic [7:0] mask;
    logic       emit;
    logic       last;
  } op_t;

  typedef struct packed {
    logic [6:0] col;
    logic [2:0] page;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== hdl/pfbw_front.sv =====
// Front end: accepts draw words, splits them into byte merge ops, queues the ops.
`default_nettype none

module pfbw_front #(
  parameter int COLUMNS = 128,
  parameter int PAGES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_func,
  input  wire logic signed [8:0]  in_column,
  input  wire logic signed [7:0]  in_row,
  input  wire logic [7:0]         in_data_bits,
  input  wire logic [3:0]         in_bit_count,
  input  wire logic               in_invert,
  input  wire logic               in_pixel_on,
  input  wire logic               in_refresh,
  input  wire pfbw_pkg::back_stat_t back_stat,
  output logic                    opq_valid,
  output pfbw_pkg::op_t           opq_head
);
  import pfbw_pkg::*;

  op_t                q_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [OPQ_AW:0]    cnt_r, cnt_nxt;

  op_t        op_a, op_b;
  logic [1:0] n_ops;
  logic [3:0] cnt;
  logic       col_ok, row_ok, accept;
  logic [2:0] r;
  logic [3:0] p1;
  logic [7:0] sum;
  logic [4:0] p2;
  logic [5:0] top;
  logic [3:0] neg_amt;
  logic [7:0] row_neg;
  logic [3:0] low;
  logic [7:0] v_neg, v1, v2;
  logic [15:0] run_mask;

  assign full = back_stat.clearing || (cnt_r > (OPQ_AW+1)'(OPQ_DEPTH - 2));
  assign accept = push && !full;
  assign opq_valid = (cnt_r != '0);
  assign opq_head = q_r[rd_r];

  always_comb begin
    cnt = (in_bit_count > 4'd8) ? 4'd8 : in_bit_count;
    col_ok = !in_column[8] && (int'(in_column[7:0]) < COLUMNS);
    row_ok = !in_row[7] && (int'(in_row[6:0]) < PAGES * 8);
    r = in_row[2:0];
    p1 = in_row[6:3];
    sum = {1'b0, in_row[6:0]} + {4'b0, cnt} - 8'd1;
    p2 = sum[7:3];
    top = {2'b0, cnt} + in_row[5:0];
    row_neg = 8'(-in_row);
    neg_amt = row_neg[3:0];
    low = {1'b0, r} + cnt - 4'd8;
    v_neg = in_data_bits >> neg_amt;
    v1 = in_data_bits << r;
    v2 = in_data_bits >> (4'd8 - {1'b0, r});
    run_mask = ((16'd1 << cnt) - 16'd1) << r;
    op_a = '0;
    op_b = '0;
    op_a.col = in_column[7:0];
    op_b.col = in_column[7:0];
    op_a.emit = in_refresh;
    op_b.emit = in_refresh;
    op_a.last = 1'b1;
    op_b.last = 1'b1;
    n_ops = 2'd0;
    if (col_ok) begin
      if (!in_func) begin
        if (row_ok) begin
          op_a.page = p1;
          op_a.val = in_pixel_on ? FULL_BYTE : 8'h00;
          op_a.mask = 8'h01 << r;
          n_ops = 2'd1;
        end
      end else if (in_row[7]) begin
        if ((in_row >= -8'sd8) && !top[5] && (top != 6'd0)) begin
          op_a.page = 4'd0;
          op_a.val = in_invert ? ~v_neg : v_neg;
          op_a.mask = 8'((9'd1 << top[3:0]) - 9'd1);
          n_ops = 2'd1;
        end
      end else if (row_ok) begin
        op_a.page = p1;
        n_ops = 2'd1;
        if (cnt == 4'd0) begin
          op_a.val = 8'h00;
          op_a.mask = 8'h00;
        end else if (p2 == {1'b0, p1}) begin
          op_a.val = in_invert ? ~v1 : v1;
          op_a.mask = run_mask[7:0];
        end else begin
          op_a.val = in_invert ? ~v1 : v1;
          op_a.mask = FULL_BYTE << r;
          if (int'(p2) < PAGES) begin
            op_a.last = 1'b0;
            op_b.page = p2[3:0];
            op_b.val = in_invert ? ~v2 : v2;
            op_b.mask = 8'((9'd1 << low) - 9'd1);
            n_ops = 2'd2;
          end
        end
      end
    end
  end

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      wr_nxt = wr_r + OPQ_AW'(n_ops);
      cnt_nxt = cnt_nxt + (OPQ_AW+1)'(n_ops);
    end
    if (back_stat.pop) begin
      rd_nxt = rd_r + OPQ_AW'(1);
      cnt_nxt = cnt_nxt - (OPQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_ops != 2'd0)) begin
      q_r[wr_r] <= op_a;
    end
    if (accept && (n_ops == 2'd2)) begin
      q_r[wr_r + OPQ_AW'(1)] <= op_b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pfbw_back.sv =====
// Back end: frame store memory, clearing pass and byte read-modify-write.
`default_nettype none

module pfbw_back #(
  parameter int COLUMNS = 128,
  parameter int PAGES = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 opq_valid,
  input  wire pfbw_pkg::op_t        opq_head,
  output pfbw_pkg::back_stat_t      back_stat,
  input  wire logic                 res_full,
  output logic                      res_push,
  output pfbw_pkg::res_t            res_word
);
  import pfbw_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;
  op_t           op_r;
  logic          start, we;
  logic [AW-1:0] head_addr, op_addr, wr_addr;
  logic [7:0]    merged, wr_data;

  assign head_addr = AW'(int'(opq_head.col) * PAGES + int'(opq_head.page));
  assign op_addr = AW'(int'(op_r.col) * PAGES + int'(op_r.page));
  assign start = (state_r == S_IDLE) && opq_valid && (!opq_head.emit || !res_full);
  assign merged = (rd_q & ~op_r.mask) | (op_r.val & op_r.mask);
  assign we = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign wr_addr = (state_r == S_CLEAR) ? clr_r : op_addr;
  assign wr_data = (state_r == S_CLEAR) ? 8'h00 : merged;

  assign back_stat.clearing = (state_r == S_CLEAR);
  assign back_stat.pop = start;

  assign res_push = (state_r == S_WRITE) && op_r.emit;
  assign res_word.col = op_r.col[6:0];
  assign res_word.page = op_r.page[2:0];
  assign res_word.data = merged;
  assign res_word.last = op_r.last;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= opq_head;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[head_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/pfbw_out_fifo.sv =====
// Result queue between the back end and the output port.
`default_nettype none

module pfbw_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_push,
  input  wire pfbw_pkg::res_t res_word,
  output logic                res_full,
  input  wire logic           pop,
  output logic                empty,
  output pfbw_pkg::res_t      head
);
  import pfbw_pkg::*;

  res_t               q_r [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [RESQ_AW:0]   cnt_r, cnt_nxt;
  logic               take;

  assign empty = (cnt_r == '0);
  assign res_full = (cnt_r == (RESQ_AW+1)'(RESQ_DEPTH));
  assign take = pop && !empty;
  assign head = q_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (res_push) begin
      wr_nxt = wr_r + RESQ_AW'(1);
      cnt_nxt = cnt_nxt + (RESQ_AW+1)'(1);
    end
    if (take) begin
      rd_nxt = rd_r + RESQ_AW'(1);
      cnt_nxt = cnt_nxt - (RESQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_r] <= res_word;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/paged_framebuffer_bit_writer.sv =====
// Top level of the paged framebuffer bit writer.
// Draw words enter through the push/full queue port; the front end turns each
// word into zero, one or two byte merge ops combinationally and queues them, so a
// word is taken every cycle while the op queue has room. The back end runs each
// op as a read then a write of the frame store memory (S_IDLE then S_WRITE) and
// takes no new op until the write is done; an op that emits waits while the
// result queue is full. Store bytes written with refresh come out of the result
// queue oldest first, with last set on the final byte of each word. After
// reset the store is cleared one byte per cycle, all COLUMNS*PAGES bytes, while
// full stays high.
`default_nettype none

module paged_framebuffer_bit_writer #(
  parameter int COLUMNS = 128,
  parameter int PAGES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_func,
  input  wire logic signed [8:0] in_column,
  input  wire logic signed [7:0] in_row,
  input  wire logic [7:0]        in_data_bits,
  input  wire logic [3:0]        in_bit_count,
  input  wire logic              in_invert,
  input  wire logic              in_pixel_on,
  input  wire logic              in_refresh,
  output logic                   empty,
  input  wire logic              pop,
  output logic [6:0]             out_column,
  output logic [2:0]             out_page,
  output logic [7:0]             out_page_byte,
  output logic                   out_last
);
  import pfbw_pkg::*;

  back_stat_t back_stat;
  logic       opq_valid;
  op_t        opq_head;
  logic       res_full, res_push;
  res_t       res_word, head;

  pfbw_front #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_func      (in_func),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_data_bits (in_data_bits),
    .in_bit_count (in_bit_count),
    .in_invert    (in_invert),
    .in_pixel_on  (in_pixel_on),
    .in_refresh   (in_refresh),
    .back_stat    (back_stat),
    .opq_valid    (opq_valid),
    .opq_head     (opq_head)
  );

  pfbw_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .opq_valid (opq_valid),
    .opq_head  (opq_head),
    .back_stat (back_stat),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  pfbw_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_word (res_word),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign out_column = head.col;
  assign out_page = head.page;
  assign out_page_byte = head.data;
  assign out_last = head.last;

endmodule

`default_nettype wire

// ===== hdl/pfbw_checker.sv =====
// Port-level checker of the paged framebuffer bit writer and its bind.
`default_nettype none

module pfbw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [6:0] out_column,
  input wire logic [2:0] out_page,
  input wire logic [7:0] out_page_byte,
  input wire logic       out_last
);

  a_reset_blocks: assert property (@(posedge clk) !rst_n |=> (full && empty))
    else $error("full and empty not both set after reset");

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result word dropped without pop");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_column) && $stable(out_page) &&
                         $stable(out_page_byte) && $stable(out_last)))
    else $error("waiting result word changed without pop");

endmodule

bind paged_framebuffer_bit_writer pfbw_checker u_pfbw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_column    (out_column),
  .out_page      (out_page),
  .out_page_byte (out_page_byte),
  .out_last      (out_last)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the paged framebuffer bit writer: directed and random draw words.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfbw_pkg::*;

  localparam int COLUMNS = 128;
  localparam int PAGES = 8;
  localparam int ROWS = PAGES * 8;
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_RUN = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 32;

  typedef struct packed {
    logic              func;
    logic signed [8:0] col;
    logic signed [7:0] row;
    logic [7:0]        data;
    logic [3:0]        cnt;
    logic              inv;
    logic              on;
    logic              refresh;
  } draw_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_func = 1'b0;
  logic signed [8:0] in_column = '0;
  logic signed [7:0] in_row = '0;
  logic [7:0]        in_data_bits = '0;
  logic [3:0]        in_bit_count = '0;
  logic              in_invert = 1'b0;
  logic              in_pixel_on = 1'b0;
  logic              in_refresh = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [6:0]        out_column;
  logic [2:0]        out_page;
  logic [7:0]        out_page_byte;
  logic              out_last;

  logic [7:0] shadow_store [COLUMNS*PAGES];
  res_t       pending_bytes [$];
  int         err_count = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         pop_stall_pct = 0;

  paged_framebuffer_bit_writer #(
    .COLUMNS(COLUMNS),
    .PAGES(PAGES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_func(in_func),
    .in_column(in_column),
    .in_row(in_row),
    .in_data_bits(in_data_bits),
    .in_bit_count(in_bit_count),
    .in_invert(in_invert),
    .in_pixel_on(in_pixel_on),
    .in_refresh(in_refresh),
    .empty(empty),
    .pop(pop),
    .out_column(out_column),
    .out_page(out_page),
    .out_page_byte(out_page_byte),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  function automatic draw_t draw(logic func, int col, int row, int data, int cnt,
                                 logic inv, logic on, logic refresh);
    draw_t w;
    w.func = func;
    w.col = 9'(col);
    w.row = 8'(row);
    w.data = 8'(data);
    w.cnt = 4'(cnt);
    w.inv = inv;
    w.on = on;
    w.refresh = refresh;
    return w;
  endfunction

  task automatic merge_byte(int c, int p, logic [7:0] v, logic [7:0] m);
    shadow_store[c*PAGES+p] = (shadow_store[c*PAGES+p] & ~m) | (v & m);
  endtask

  function automatic res_t snap(int c, int p);
    res_t b;
    b.col = 7'(c);
    b.page = 3'(p);
    b.data = shadow_store[c*PAGES+p];
    b.last = 1'b0;
    return b;
  endfunction

  task automatic apply_draw(draw_t w);
    int c, r, cnt, top, p1, p2, sh, low;
    logic [7:0] v, m;
    res_t emitted [$];
    c = $signed(w.col);
    r = $signed(w.row);
    cnt = (w.cnt > 8) ? 8 : int'(w.cnt);
    if (c >= 0 && c < COLUMNS) begin
      if (w.func == FUNC_PIXEL) begin
        if (r >= 0 && r < ROWS) begin
          m = 8'(1 << (r & 7));
          merge_byte(c, r >> 3, w.on ? FULL_BYTE : 8'h00, m);
          if (w.refresh) emitted.push_back(snap(c, r >> 3));
        end
      end else if (r < 0) begin
        top = cnt + r;
        if (r >= -8 && top > 0) begin
          v = w.data >> (-r);
          if (w.inv) v = ~v;
          m = 8'((1 << top) - 1);
          merge_byte(c, 0, v, m);
          if (w.refresh) emitted.push_back(snap(c, 0));
        end
      end else if (r < ROWS) begin
        p1 = r >> 3;
        sh = r & 7;
        if (cnt == 0) begin
          if (w.refresh) emitted.push_back(snap(c, p1));
        end else begin
          p2 = (r + cnt - 1) >> 3;
          v = 8'(w.data << sh);
          if (w.inv) v = ~v;
          if (p1 == p2) begin
            m = 8'(((1 << cnt) - 1) << sh);
            merge_byte(c, p1, v, m);
            if (w.refresh) emitted.push_back(snap(c, p1));
          end else begin
            merge_byte(c, p1, v, 8'(FULL_BYTE << sh));
            if (w.refresh) emitted.push_back(snap(c, p1));
            if (p2 < PAGES) begin
              low = sh + cnt - 8;
              v = w.data >> (8 - sh);
              if (w.inv) v = ~v;
              m = 8'((1 << low) - 1);
              merge_byte(c, p2, v, m);
              if (w.refresh) emitted.push_back(snap(c, p2));
            end
          end
        end
      end
    end
    if (emitted.size() > 0) emitted[emitted.size()-1].last = 1'b1;
    foreach (emitted[i]) pending_bytes.push_back(emitted[i]);
  endtask

  task automatic send_word(draw_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_func <= w.func;
    in_column <= w.col;
    in_row <= w.row;
    in_data_bits <= w.data;
    in_bit_count <= w.cnt;
    in_invert <= w.inv;
    in_pixel_on <= w.on;
    in_refresh <= w.refresh;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_draw(w);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic draw_t rand_draw();
    draw_t w;
    int sel;
    w.func = 1'($urandom);
    sel = $urandom_range(99);
    if (sel < 50) w.col = 9'($urandom_range(3));
    else if (sel < 85) w.col = 9'($urandom_range(COLUMNS-1));
    else w.col = 9'($urandom);
    sel = $urandom_range(99);
    if (sel < 70) w.row = 8'(int'($urandom_range(ROWS+7)) - 8);
    else if (sel < 85) w.row = 8'(int'($urandom_range(ROWS-1, ROWS-8)));
    else w.row = 8'($urandom);
    w.data = 8'($urandom);
    w.cnt = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
    w.inv = 1'($urandom);
    w.on = 1'($urandom);
    w.refresh = ($urandom_range(99) < 85);
    return w;
  endfunction

  task automatic test_pixels();
    send_word(draw(FUNC_PIXEL, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, COLUMNS-1, ROWS-1, 8'hff, 15, 1'b1, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, COLUMNS-1, ROWS-1, 0, 0, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_PIXEL, 5, 12, 0, 0, 1'b0, 1'b1, 1'b0));
    send_word(draw(FUNC_PIXEL, 5, 13, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, 5, ROWS, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, 5, -1, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, -1, 3, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, COLUMNS, 3, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, 255, 127, 0, 0, 1'b0, 1'b1, 1'b1));
    send_word(draw(FUNC_PIXEL, -256, -128, 0, 0, 1'b0, 1'b1, 1'b1));
  endtask

  task automatic test_runs();
    send_word(draw(FUNC_RUN, 7, 5, 8'hff, 0, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, -3, 8'hff, 0, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, 8, 8'hff, 8, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, 13, 8'h00, 8, 1'b1, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, 13, 8'ha5, 15, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, 13, 8'h5a, 3, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, -3, 8'hff, 5, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, -8, 8'hff, 8, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, -7, 8'h80, 8, 1'b1, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, -9, 8'hff, 8, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, ROWS-4, 8'hff, 8, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, ROWS, 8'hff, 8, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, 127, 8'hff, 8, 1'b0, 1'b0, 1'b1));
    send_word(draw(FUNC_RUN, 7, -128, 8'hff, 8, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (n) send_word(rand_draw());
    wait_drained();
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected word col=%0d page=%0d byte=%02h last=%0b",
                 $time, out_column, out_page, out_page_byte, out_last);
        err_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_column != want.col) begin
          $display("%0t: column expected %0d actual %0d", $time, want.col, out_column);
          err_count++;
        end
        if (out_page != want.page) begin
          $display("%0t: page expected %0d actual %0d", $time, want.page, out_page);
          err_count++;
        end
        if (out_page_byte != want.data) begin
          $display("%0t: byte expected %02h actual %02h", $time, want.data, out_page_byte);
          err_count++;
        end
        if (out_last != want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          err_count++;
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_pixels();
    test_runs();
    wait_drained();
    test_random(175, 0, 0);
    test_random(175, 53, 0);
    test_random(175, 0, 53);
    test_random(175, 25, 25);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pfbw_pkg.sv
hdl/pfbw_front.sv
hdl/pfbw_back.sv
hdl/pfbw_out_fifo.sv
hdl/paged_framebuffer_bit_writer.sv
hdl/pfbw_checker.sv
test/tb.sv
